// ===== rtl/core/cpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_pkg
// Shared types and constants of the complex permittivity interpolator.
// ----------------------------------------------------------------------------
package cpi_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REGION_INTERP = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    localparam int KEY_W   = 24;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 8;
    localparam int LEN_W   = 9;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 80;
    // divider: 57-bit product padded to an even width, two quotient bits per cycle
    localparam int DVD_W   = 58;
    localparam int DVS_W   = 24;
    localparam int DIV_CYC = DVD_W / 2;

    localparam logic [0:0] ADDR_LENGTH = 1'b0;
    localparam logic [0:0] ADDR_MODE   = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [SLOT_W-1:0]        slot;
        logic [KEY_W-1:0]         lam;
        logic signed [VAL_W-1:0]  ereal;
        logic signed [VAL_W-1:0]  eimag;
    } item_t;

endpackage

// ===== rtl/core/cpi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_front
// Input side: unpack the beat, drop loads aimed past the table, push the rest.
// ----------------------------------------------------------------------------
module cpi_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [cpi_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tuser,
    input  logic                      q_full,
    output logic                      q_push,
    output cpi_pkg::item_t            q_item
);

    logic slot_ok;

    always_comb
    begin
        q_item.op    = s_tuser;
        q_item.slot  = s_tdata[7:0];
        q_item.lam   = s_tdata[31:8];
        q_item.ereal = s_tdata[63:32];
        q_item.eimag = s_tdata[95:64];
    end

    assign slot_ok  = ({24'd0, q_item.slot} < 32'(TABLE_DEPTH));
    assign s_tready = !q_full;
    // accept the beat but drop a load beyond the table
    assign q_push   = s_tvalid && s_tready && ((q_item.op == cpi_pkg::OP_QUERY) || slot_ok);

endmodule

// ===== rtl/core/cpi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_fifo
// Two-entry queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module cpi_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpi_pkg::item_t  din,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output cpi_pkg::item_t  dout
);

    cpi_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== rtl/core/cpi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_div
// Two-lane restoring divider with a shared divisor, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module cpi_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cpi_pkg::DVD_W-1:0]   dvd_a,
    input  logic [cpi_pkg::DVD_W-1:0]   dvd_b,
    input  logic [cpi_pkg::DVS_W-1:0]   dvs,
    output logic                        done,
    output logic [cpi_pkg::DVD_W-1:0]   quo_a,
    output logic [cpi_pkg::DVD_W-1:0]   quo_b
);

    localparam int CW = $clog2(cpi_pkg::DIV_CYC + 1);

    logic [cpi_pkg::DVD_W-1:0] wa_reg;
    logic [cpi_pkg::DVD_W-1:0] wb_reg;
    logic [cpi_pkg::DVS_W-1:0] ra_reg;
    logic [cpi_pkg::DVS_W-1:0] rb_reg;
    logic [cpi_pkg::DVS_W-1:0] dvs_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      done_reg;
    logic [cpi_pkg::DVS_W:0]   a1, a2, b1, b2;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [cpi_pkg::DVS_W:0] div_step(
        input logic [cpi_pkg::DVS_W-1:0] rem,
        input logic                      nbit,
        input logic [cpi_pkg::DVS_W-1:0] d
    );
        logic [cpi_pkg::DVS_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, d})
            div_step = {1'b1, cpi_pkg::DVS_W'(t - {1'b0, d})};
        else
            div_step = {1'b0, t[cpi_pkg::DVS_W-1:0]};
    endfunction

    always_comb
    begin
        a1 = div_step(ra_reg, wa_reg[cpi_pkg::DVD_W-1], dvs_reg);
        a2 = div_step(a1[cpi_pkg::DVS_W-1:0], wa_reg[cpi_pkg::DVD_W-2], dvs_reg);
        b1 = div_step(rb_reg, wb_reg[cpi_pkg::DVD_W-1], dvs_reg);
        b2 = div_step(b1[cpi_pkg::DVS_W-1:0], wb_reg[cpi_pkg::DVD_W-2], dvs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(cpi_pkg::DIV_CYC);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            wa_reg  <= dvd_a;
            wb_reg  <= dvd_b;
            ra_reg  <= '0;
            rb_reg  <= '0;
            dvs_reg <= dvs;
        end
        else if (cnt_reg != '0)
        begin
            wa_reg <= {wa_reg[cpi_pkg::DVD_W-3:0], a1[cpi_pkg::DVS_W], a2[cpi_pkg::DVS_W]};
            wb_reg <= {wb_reg[cpi_pkg::DVD_W-3:0], b1[cpi_pkg::DVS_W], b2[cpi_pkg::DVS_W]};
            ra_reg <= a2[cpi_pkg::DVS_W-1:0];
            rb_reg <= b2[cpi_pkg::DVS_W-1:0];
        end
    end

    assign done  = done_reg;
    assign quo_a = wa_reg;
    assign quo_b = wb_reg;

endmodule

// ===== rtl/core/cpi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_back
// Back sequencer: table memories, load squaring, segment walk, interpolation.
// ----------------------------------------------------------------------------
module cpi_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  cpi_pkg::item_t              item,
    output logic                        item_pop,
    input  logic [cpi_pkg::LEN_W-1:0]   cfg_len,
    input  logic                        cfg_mode,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cpi_pkg::OUT_W-1:0]   m_tdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int LW = (IW + 1 > cpi_pkg::LEN_W) ? IW + 1 : cpi_pkg::LEN_W;
    localparam logic signed [64:0] SAT_MAX = 65'sh0_7FFF_FFFF;
    localparam logic signed [64:0] SAT_MIN = -65'sh0_8000_0000;

    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_LMUL = 19'h00002,
        S_LWR  = 19'h00004,
        S_FRD  = 19'h00008,
        S_FCHK = 19'h00010,
        S_BRD  = 19'h00020,
        S_BCHK = 19'h00040,
        S_E0   = 19'h00080,
        S_EL   = 19'h00100,
        S_DEC  = 19'h00200,
        S_ILO  = 19'h00400,
        S_IHI  = 19'h00800,
        S_CALC = 19'h01000,
        S_MUL  = 19'h02000,
        S_DST  = 19'h04000,
        S_DIV  = 19'h08000,
        S_VRD  = 19'h10000,
        S_VCAP = 19'h20000,
        S_OUT  = 19'h40000
    } state_t;

    state_t                 state_reg;
    cpi_pkg::item_t         item_reg;
    logic [IW-1:0]          p_reg;
    logic [IW-1:0]          last_reg;
    logic [IW-1:0]          idx_reg;
    logic [7:0]             sp_reg;
    logic [7:0]             seg_reg;
    logic [1:0]             region_reg;
    logic [23:0]            k0_reg;
    logic [23:0]            klo_reg;
    logic [31:0]            rlo_reg;
    logic [31:0]            ilo_reg;
    logic [32:0]            mag_r_reg;
    logic [32:0]            mag_i_reg;
    logic                   neg_r_reg;
    logic                   neg_i_reg;
    logic [23:0]            num_reg;
    logic [23:0]            den_reg;
    logic [56:0]            pr_r_reg;
    logic [56:0]            pr_i_reg;
    logic [31:0]            res_r_reg;
    logic [31:0]            res_i_reg;
    logic signed [63:0]     aa_reg;
    logic signed [63:0]     bb_reg;
    logic signed [63:0]     ab_reg;
    logic                   m_valid_reg;
    logic [cpi_pkg::OUT_W-1:0] m_data_reg;

    logic [23:0]            key_mem [TABLE_DEPTH];
    logic [31:0]            re_mem  [TABLE_DEPTH];
    logic [31:0]            im_mem  [TABLE_DEPTH];
    logic [23:0]            key_q;
    logic [31:0]            re_q;
    logic [31:0]            im_q;
    logic [IW-1:0]          rd_addr;

    logic [LW-1:0]          len_x;
    logic [LW-1:0]          n_x;
    logic [IW-1:0]          last_x;
    logic [IW-1:0]          p_x;
    logic signed [64:0]     dsq;
    logic signed [64:0]     dab;
    logic signed [64:0]     t_re;
    logic signed [64:0]     t_im;
    logic [31:0]            sq_re;
    logic [31:0]            sq_im;
    logic signed [24:0]     num_x;
    logic signed [24:0]     den_x;
    logic signed [32:0]     dr_x;
    logic signed [32:0]     di_x;
    logic                   div_done;
    logic [cpi_pkg::DVD_W-1:0] quo_r;
    logic [cpi_pkg::DVD_W-1:0] quo_i;
    logic [31:0]            qr;
    logic [31:0]            qi;
    logic                   out_free;

    assign item_pop = (state_reg == S_IDLE) && item_valid;
    assign out_free = !m_valid_reg || m_tready;

    // entries in use clamp to 1..TABLE_DEPTH; a kept pointer past the last entry is pulled back to it
    always_comb
    begin
        len_x  = LW'(cfg_len);
        if (len_x == '0)
            n_x = LW'(1);
        else if (len_x > LW'(TABLE_DEPTH))
            n_x = LW'(TABLE_DEPTH);
        else
            n_x = len_x;
        last_x = IW'(n_x - LW'(1));
        if (LW'(sp_reg) > LW'(last_x))
            p_x = last_x;
        else
            p_x = IW'(sp_reg);
    end

    always_comb
    begin
        case (state_reg)
            S_FRD:   rd_addr = p_reg;
            S_BRD:   rd_addr = p_reg - IW'(1);
            S_E0:    rd_addr = '0;
            S_EL:    rd_addr = last_reg;
            S_ILO:   rd_addr = p_reg - IW'(1);
            S_IHI:   rd_addr = p_reg;
            S_VRD:   rd_addr = idx_reg;
            default: rd_addr = p_reg;
        endcase
    end

    // squaring: truncate toward zero, then saturate
    always_comb
    begin
        dsq  = 65'(aa_reg) - 65'(bb_reg);
        dab  = 65'(ab_reg);
        t_re = (dsq >>> 20) + (((dsq < 0) && (dsq[19:0] != '0)) ? 65'sd1 : 65'sd0);
        t_im = (dab >>> 19) + (((dab < 0) && (dab[18:0] != '0)) ? 65'sd1 : 65'sd0);
        if (t_re > SAT_MAX)
            sq_re = 32'h7FFF_FFFF;
        else if (t_re < SAT_MIN)
            sq_re = 32'h8000_0000;
        else
            sq_re = t_re[31:0];
        if (t_im > SAT_MAX)
            sq_im = 32'h7FFF_FFFF;
        else if (t_im < SAT_MIN)
            sq_im = 32'h8000_0000;
        else
            sq_im = t_im[31:0];
    end

    always_comb
    begin
        num_x = $signed({1'b0, item_reg.lam}) - $signed({1'b0, klo_reg});
        den_x = $signed({1'b0, key_q}) - $signed({1'b0, klo_reg});
        dr_x  = $signed({re_q[31], re_q}) - $signed({rlo_reg[31], rlo_reg});
        di_x  = $signed({im_q[31], im_q}) - $signed({ilo_reg[31], ilo_reg});
        qr    = quo_r[31:0];
        qi    = quo_i[31:0];
    end

    cpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DST),
        .dvd_a ({1'b0, pr_r_reg}),
        .dvd_b ({1'b0, pr_i_reg}),
        .dvs   (den_reg),
        .done  (div_done),
        .quo_a (quo_r),
        .quo_b (quo_i)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LWR)
        begin
            key_mem[IW'(item_reg.slot)] <= item_reg.lam;
            re_mem[IW'(item_reg.slot)]  <= cfg_mode ? sq_re : item_reg.ereal;
            im_mem[IW'(item_reg.slot)]  <= cfg_mode ? sq_im : item_reg.eimag;
        end
        key_q <= key_mem[rd_addr];
        re_q  <= re_mem[rd_addr];
        im_q  <= im_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sp_reg      <= 8'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // a new beat in S_OUT takes the place of the one leaving
            if (m_valid_reg && m_tready && (state_reg != S_OUT))
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                        state_reg <= (item.op == cpi_pkg::OP_QUERY) ? S_FRD : S_LMUL;
                end
                S_LMUL: state_reg <= S_LWR;
                S_LWR:  state_reg <= S_IDLE;
                S_FRD:  state_reg <= S_FCHK;
                S_FCHK:
                begin
                    if ((key_q < item_reg.lam) && (p_reg != last_reg))
                        state_reg <= S_FRD;
                    else
                        state_reg <= S_BRD;
                end
                S_BRD:  state_reg <= (p_reg == '0) ? S_E0 : S_BCHK;
                S_BCHK: state_reg <= (key_q >= item_reg.lam) ? S_BRD : S_E0;
                S_E0:   state_reg <= S_EL;
                S_EL:   state_reg <= S_DEC;
                S_DEC:
                begin
                    sp_reg  <= 8'(p_reg);
                    if ((item_reg.lam <= k0_reg) || (item_reg.lam >= key_q))
                        state_reg <= S_VRD;
                    else
                        state_reg <= S_ILO;
                end
                S_ILO:  state_reg <= S_IHI;
                S_IHI:  state_reg <= S_CALC;
                S_CALC: state_reg <= ((den_x <= 0) || (num_x <= 0)) ? S_OUT : S_MUL;
                S_MUL:  state_reg <= S_DST;
                S_DST:  state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_OUT;
                end
                S_VRD:  state_reg <= S_VCAP;
                S_VCAP: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= item;
                last_reg <= last_x;
                p_reg    <= p_x;
            end
            S_LMUL:
            begin
                aa_reg <= item_reg.ereal * item_reg.ereal;
                bb_reg <= item_reg.eimag * item_reg.eimag;
                ab_reg <= item_reg.ereal * item_reg.eimag;
            end
            S_FCHK:
            begin
                if ((key_q < item_reg.lam) && (p_reg != last_reg))
                    p_reg <= p_reg + IW'(1);
            end
            S_BCHK:
            begin
                if (key_q >= item_reg.lam)
                    p_reg <= p_reg - IW'(1);
            end
            S_EL:   k0_reg <= key_q;
            S_DEC:
            begin
                seg_reg <= 8'(p_reg);
                if (item_reg.lam <= k0_reg)
                begin
                    region_reg <= cpi_pkg::REGION_BELOW;
                    idx_reg    <= '0;
                end
                else if (item_reg.lam >= key_q)
                begin
                    region_reg <= cpi_pkg::REGION_ABOVE;
                    idx_reg    <= last_reg;
                end
                else
                    region_reg <= cpi_pkg::REGION_INTERP;
            end
            S_IHI:
            begin
                klo_reg <= key_q;
                rlo_reg <= re_q;
                ilo_reg <= im_q;
            end
            S_CALC:
            begin
                // degenerate segment: take the upper entry
                res_r_reg <= re_q;
                res_i_reg <= im_q;
                neg_r_reg <= dr_x[32];
                neg_i_reg <= di_x[32];
                mag_r_reg <= dr_x[32] ? 33'(-dr_x) : 33'(dr_x);
                mag_i_reg <= di_x[32] ? 33'(-di_x) : 33'(di_x);
                num_reg   <= num_x[23:0];
                den_reg   <= den_x[23:0];
            end
            S_MUL:
            begin
                pr_r_reg <= {24'd0, mag_r_reg} * {33'd0, num_reg};
                pr_i_reg <= {24'd0, mag_i_reg} * {33'd0, num_reg};
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_r_reg <= rlo_reg + (neg_r_reg ? (32'd0 - qr) : qr);
                    res_i_reg <= ilo_reg + (neg_i_reg ? (32'd0 - qi) : qi);
                end
            end
            S_VCAP:
            begin
                res_r_reg <= re_q;
                res_i_reg <= im_q;
            end
            S_OUT:
            begin
                if (out_free)
                    m_data_reg <= {6'd0, region_reg, seg_reg, res_i_reg, res_r_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/complex_permittivity_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_permittivity_interpolator
// Wavelength table of complex permittivity with piecewise-linear lookup.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries load and query beats (tuser = op). A load
// writes one table entry and gives no result; a query gives one master beat
// with the interpolated value, the segment and the region. table_length and
// index_mode are set over the APB port while the block is idle.
// A load is squared (in mode 1) and written by the back sequencer; a query
// walks the segment pointer from the kept position, then clamps or interpolates
// through the two-bit-per-cycle divider. The queue registers each item between
// accept and start. One item is worked on at a time; the two-entry queue keeps
// accepting while the sequencer is busy, until it is full. The output register
// holds a finished result while the receiver stalls, and the next item is
// worked on meanwhile up to its final write. Reset clears the queue, the
// sequencer, the segment pointer and the registers (length 1, mode 0); table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module complex_permittivity_interpolator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // entry_slot[7:0], wavelength[31:8], entry_real[63:32], entry_imag[95:64]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // eps_real[31:0], eps_im[63:32], segment[71:64], region[73:72]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cpi_pkg::LEN_W-1:0] len_reg;
    logic                      mode_reg;
    logic                      q_full;
    logic                      q_push;
    logic                      q_valid;
    logic                      q_pop;
    cpi_pkg::item_t            q_in;
    cpi_pkg::item_t            q_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cpi_pkg::ADDR_MODE) ? {31'd0, mode_reg} : {23'd0, len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 9'd1;
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == cpi_pkg::ADDR_LENGTH)
                len_reg <= pwdata[8:0];
            else
                mode_reg <= pwdata[0];
        end
    end

    cpi_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    cpi_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_out)
    );

    cpi_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_out),
        .item_pop   (q_pop),
        .cfg_len    (len_reg),
        .cfg_mode   (mode_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== rtl/core/cpi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module cpi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result beat right after reset");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[73:72] != 2'd3) && (m_tdata[79:74] == 6'd0))
        else $error("bad region code or padding");

    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2]) ##1 (psel && !pwrite && paddr[2])
        |-> prdata[0] == $past(pwdata[0]))
        else $error("mode register read back wrong");

    a_pready_high: assert property (@(posedge clk) pready)
        else $error("pready dropped");

endmodule

bind complex_permittivity_interpolator cpi_checker u_cpi_checker (.*);
